// ===== sv/ttme_pkg.sv =====
// ttme_pkg: shared types and sizes for the tournament tree block
// no dependencies; imported by ttme_ram users and the top level
package ttme_pkg;

  localparam int LEAVES   = 64;
  localparam int KEY_BITS = 48;

  // fixed item field widths
  localparam int IDX_FIELD_W  = 6;
  localparam int TIME_FIELD_W = 48;
  localparam int DATA_W       = ((IDX_FIELD_W + TIME_FIELD_W + 7) / 8) * 8;

  // tree geometry: 1-based heap positions, leaves at LEAVES .. 2*LEAVES-1
  localparam int LVL     = $clog2(LEAVES);
  localparam int HB      = (LVL > 1) ? $clog2(LVL) : 1;
  localparam int A_W     = LVL + 1;
  localparam int NODES   = 2 * LEAVES;
  localparam int ENTRY_W = LVL + KEY_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_OUT
  } state_t;

endpackage

// ===== sv/ttme_ram.sv =====
// ttme_ram: generic single-write, single-read RAM with registered read
// no package dependencies
module ttme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tournament_tree_min_event.sv =====
// tournament_tree_min_event: winner tree giving the earliest event time over all leaves
// depends on ttme_pkg and ttme_ram (one entry per tree position: winner index and key)
//
//  channel | ports                  | contents (lowest bits first)
//  --------+------------------------+-----------------------------------------------
//  in      | in_tvalid/tready/tdata | leaf_index[5:0], new_time[53:6], zero pad
//  out     | out_tvalid/tready/tdata| winner_index[5:0], winner_time[53:6], zero pad
//
// an item passes an accept step, a leaf write, LVL compare steps (6 for 64 leaves)
// and a result step that holds until the result is taken; the walk is paced by the
// single tree RAM read port, which fetches one sibling per level
// the block holds one item at a time; in_tready is low until the result is taken
// reset clears a valid bit per tree position at once; an unwritten position reads as
// an empty key with the leftmost leaf of its subtree, so no clearing pass is needed
module tournament_tree_min_event (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ttme_pkg::DATA_W-1:0] in_tdata,   // leaf_index, new_time
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ttme_pkg::DATA_W-1:0] out_tdata   // winner_index, winner_time
);
  import ttme_pkg::*;

  state_t              st_r, st_nxt;
  logic [HB-1:0]       h_r, h_nxt;
  logic [LVL-1:0]      leaf_r, leaf_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [LVL-1:0]      cur_idx_r, cur_idx_nxt;
  logic [KEY_BITS-1:0] cur_key_r, cur_key_nxt;
  logic [NODES-1:0]    vld_r;
  logic                sib_vld_r;

  logic                rd_en, wr_en;
  logic [A_W-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0]  wr_data, rd_data;

  logic [A_W-1:0]      path, up;
  logic [HB:0]         sh;
  logic [LVL-1:0]      one_h, low_mask, rst_idx, sib_idx;
  logic [KEY_BITS-1:0] sib_key;
  logic                side, take_sib;
  logic [LVL-1:0]      win_idx;
  logic [KEY_BITS-1:0] win_key;

  ttme_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODES)
  ) u_tree (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // heap position of the leaf, and of the node one level above the current one
  assign path = {1'b1, leaf_r};
  assign sh   = {1'b0, h_r} + 1'b1;
  assign up   = path >> sh;

  // sibling subtree at height h starts at the leaf with bit h flipped, low bits clear
  assign one_h    = LVL'(1) << h_r;
  assign low_mask = one_h - LVL'(1);
  assign rst_idx  = (leaf_r ^ one_h) & ~low_mask;
  assign sib_idx  = sib_vld_r ? rd_data[ENTRY_W-1:KEY_BITS] : rst_idx;
  assign sib_key  = sib_vld_r ? rd_data[KEY_BITS-1:0] : '1;

  // left wins a tie
  assign side     = leaf_r[h_r];
  assign take_sib = side ? (sib_key <= cur_key_r) : (sib_key < cur_key_r);
  assign win_idx  = take_sib ? sib_idx : cur_idx_r;
  assign win_key  = take_sib ? sib_key : cur_key_r;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {(DATA_W - IDX_FIELD_W - TIME_FIELD_W)'(0),
                       TIME_FIELD_W'(cur_key_r), IDX_FIELD_W'(cur_idx_r)};

  always_comb begin
    st_nxt      = st_r;
    h_nxt       = h_r;
    leaf_nxt    = leaf_r;
    key_nxt     = key_r;
    cur_idx_nxt = cur_idx_r;
    cur_key_nxt = cur_key_r;
    rd_en       = 1'b0;
    rd_addr     = up ^ A_W'(1);
    wr_en       = 1'b0;
    wr_addr     = up;
    wr_data     = {win_idx, win_key};
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          leaf_nxt    = LVL'(in_tdata[IDX_FIELD_W-1:0]);
          key_nxt     = KEY_BITS'(in_tdata[IDX_FIELD_W +: TIME_FIELD_W]);
          cur_idx_nxt = LVL'(in_tdata[IDX_FIELD_W-1:0]);
          cur_key_nxt = KEY_BITS'(in_tdata[IDX_FIELD_W +: TIME_FIELD_W]);
          h_nxt       = '0;
          st_nxt      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // store the leaf and fetch its sibling
        wr_en   = 1'b1;
        wr_addr = path;
        wr_data = {leaf_r, key_r};
        rd_en   = 1'b1;
        rd_addr = path ^ A_W'(1);
        st_nxt  = ST_WALK;
      end
      ST_WALK: begin
        cur_idx_nxt = win_idx;
        cur_key_nxt = win_key;
        wr_en       = 1'b1;
        if (h_r == HB'(LVL - 1)) begin
          st_nxt = ST_OUT;
        end else begin
          rd_en = 1'b1;
          h_nxt = h_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      h_r   <= '0;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      h_r  <= h_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    leaf_r    <= leaf_nxt;
    key_r     <= key_nxt;
    cur_idx_r <= cur_idx_nxt;
    cur_key_r <= cur_key_nxt;
    if (rd_en) begin
      sib_vld_r <= vld_r[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result side active together");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("tree RAM read and write hit the same position");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (h_r <= HB'(LVL - 1)))
    else $error("walk level beyond the root");

  a_result_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(st_r) == ST_WALK && $past(h_r) == HB'(LVL - 1)))
    else $error("result raised before the walk reached the root");

  a_winner_not_later: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cur_key_r <= key_r))
    else $error("winner later than the time just written");
`endif

endmodule

// ===== tb/sv/ttme_checker.sv =====
`timescale 1ns / 100ps
// ttme_checker: watches the in and out streams of tournament_tree_min_event,
// keeps its own winner tree to predict each result and compares field by field
// depends on ttme_pkg for the stream width and the tree size
module ttme_checker
  import ttme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,
  output int                mismatches,
  output int                pending
);

  localparam int INNER = LEAVES - 1;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0]  win_idx;
    logic [TIME_FIELD_W-1:0] win_ticks;
  } winner_t;

  logic [KEY_BITS-1:0] leaf_ticks [LEAVES];
  logic [LVL-1:0]      node_win   [INNER];
  winner_t             due_winners [$];

  initial mismatches = 0;
  initial pending = 0;

  // positions INNER and up are the leaves themselves
  function automatic logic [LVL-1:0] pos_winner(input int pos);
    if (pos >= INNER) return LVL'(pos - INNER);
    return node_win[pos];
  endfunction

  function automatic void clear_tree();
    int p;
    for (int n = 0; n < LEAVES; n++) leaf_ticks[n] = '1;
    for (int n = 0; n < INNER; n++) begin
      p = n;
      while (p < INNER) p = 2 * p + 1;
      node_win[n] = LVL'(p - INNER);
    end
  endfunction

  // store the new time, replay the compares up to the root, return the root winner
  function automatic winner_t update_leaf(input logic [IDX_FIELD_W-1:0] leaf,
                                          input logic [TIME_FIELD_W-1:0] ticks);
    int pos;
    int parent;
    logic [LVL-1:0] lw;
    logic [LVL-1:0] rw;
    winner_t w;
    pos = INNER + (int'(leaf) % LEAVES);
    leaf_ticks[int'(leaf) % LEAVES] = KEY_BITS'(ticks);
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      lw = pos_winner(2 * parent + 1);
      rw = pos_winner(2 * parent + 2);
      node_win[parent] = (leaf_ticks[lw] <= leaf_ticks[rw]) ? lw : rw;
      pos = parent;
    end
    w.win_idx   = IDX_FIELD_W'(pos_winner(0));
    w.win_ticks = TIME_FIELD_W'(leaf_ticks[pos_winner(0)]);
    return w;
  endfunction

  always @(posedge clk) begin
    winner_t want;
    logic [IDX_FIELD_W-1:0]  got_idx;
    logic [TIME_FIELD_W-1:0] got_ticks;
    if (!rst_n) begin
      clear_tree();
      due_winners.delete();
    end else begin
      if (in_tvalid && in_tready)
        due_winners.insert(due_winners.size(),
                           update_leaf(in_tdata[IDX_FIELD_W-1:0],
                                       in_tdata[IDX_FIELD_W +: TIME_FIELD_W]));
      if (out_tvalid && out_tready) begin
        got_idx   = out_tdata[IDX_FIELD_W-1:0];
        got_ticks = out_tdata[IDX_FIELD_W +: TIME_FIELD_W];
        if (due_winners.size() == 0) begin
          $error("result with nothing expected: winner_index %0d winner_time %h",
                 got_idx, got_ticks);
          mismatches++;
        end else begin
          want = due_winners.pop_front();
          if (got_idx !== want.win_idx) begin
            $error("winner_index: expected %0d, got %0d", want.win_idx, got_idx);
            mismatches++;
          end
          if (got_ticks !== want.win_ticks) begin
            $error("winner_time: expected %h, got %h", want.win_ticks, got_ticks);
            mismatches++;
          end
        end
      end
    end
    pending <= due_winners.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for tournament_tree_min_event
// depends on ttme_pkg, the block itself and ttme_checker, which does all the checking
module tb_top;
  import ttme_pkg::*;

  localparam int RANDOM_ITEMS = 1035;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PAD_W        = DATA_W - IDX_FIELD_W - TIME_FIELD_W;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  logic                    calm       = 1'b0;
  logic [IDX_FIELD_W-1:0]  last_idx   = '0;
  logic [TIME_FIELD_W-1:0] last_ticks = '1;
  int                      mismatches;
  int                      pending;
  int                      cycles     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tournament_tree_min_event dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ttme_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 22);
  end

  // the current front of the queue steers the scheduler-like stimulus
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      last_idx   <= out_tdata[IDX_FIELD_W-1:0];
      last_ticks <= out_tdata[IDX_FIELD_W +: TIME_FIELD_W];
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_update(input logic [IDX_FIELD_W-1:0] leaf,
                             input logic [TIME_FIELD_W-1:0] ticks);
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, ticks, leaf};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [TIME_FIELD_W-1:0] wide_ticks();
    return TIME_FIELD_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [IDX_FIELD_W-1:0]  leaf;
    logic [TIME_FIELD_W-1:0] ticks;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all slots empty: leftmost leaf wins with an all-ones time
    push_update(6'd10, '1);
    push_update(6'd63, '0);
    // equal times, left subtree wins
    push_update(6'd0, '0);
    push_update(6'd0, 48'h1);
    push_update(6'd63, '1);
    push_update(6'd31, 48'h1);
    push_update(6'd32, 48'h1);
    push_update(6'd0, '1);
    push_update(6'd31, 48'hAAAA_AAAA_AAAA);
    push_update(6'd32, 48'h5555_5555_5555);
    push_update(6'd33, 48'h7FFF_FFFF_FFFF);
    push_update(6'd1, 48'h8000_0000_0000);
    push_update(6'd42, 48'hFFFF_FFFF_FFFE);
    push_update(6'd21, '0);
    push_update(6'd42, '0);
    push_update(6'd21, '1);
    push_update(6'd42, '1);
    push_update(6'd63, 48'h1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) calm <= 1'b1;
      if (n == 520) calm <= 1'b0;
      pick = $urandom_range(99);
      leaf = IDX_FIELD_W'($urandom_range(LEAVES - 1));
      if (pick < 40) begin
        // the earliest actor fires and reschedules itself later
        leaf  = last_idx;
        ticks = last_ticks + TIME_FIELD_W'($urandom_range(1, 1000));
      end else if (pick < 60) begin
        // close to the front, so ties and takeovers are frequent
        ticks = last_ticks + TIME_FIELD_W'($urandom_range(0, 200));
      end else if (pick < 72) begin
        ticks = '1;
      end else if (pick < 76) begin
        ticks = '0;
      end else begin
        ticks = wide_ticks();
      end
      push_update(leaf, ticks);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
